FILE: rtl/core/tthc_pkg.sv
package tthc_pkg;

	localparam int FACE_W     = 3;
	localparam int LEVEL_W    = 5;
	localparam int COORD_W    = 30;
	localparam int ID_W       = 64;
	localparam int FACE_SHIFT = 61;
	localparam int MAX_FACE   = 5;

	// Datapath commands issued by the sequencer.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath status back to the sequencer.
	typedef struct packed {
		logic done;
	} sts_t;

endpackage

FILE: rtl/core/tile_to_hilbert_cell_id_core.sv
// Flow: an accepted input beat is loaded, then stepped once per level digit,
//   then finished once the output register is free, which packs the id.
// Throughput: in_stall holds a new beat off until the current one is
//   finished; rejected and level-zero items skip the digit steps.
// Reset: arst_n clears the sequencer and the output valid flag at once;
//   payload registers are not reset.
module tile_to_hilbert_cell_id_core #(
	parameter int MAX_LEVEL = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tthc_pkg::FACE_W-1:0]   face,
	input  logic [tthc_pkg::LEVEL_W-1:0]  level,
	input  logic [tthc_pkg::COORD_W-1:0]  x_coord,
	input  logic [tthc_pkg::COORD_W-1:0]  y_coord,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tthc_pkg::ID_W-1:0]     cell_id,
	output logic                          rejected
);
	import tthc_pkg::*;

	// Commands from the sequencer, status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	// Sequencer: take a beat when idle, advance one level per cycle, and
	// wait until the output register is free before the result is packed.
	tthc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: swap coordinates on odd faces, peel off one Hilbert digit
	// per level from the top, rotate or reflect the remaining bits, then
	// pack face, index and level marker into the output register. The
	// output register lets the next beat enter while a result waits.
	tthc_datapath #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.face     (face),
		.level    (level),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.cell_id  (cell_id),
		.rejected (rejected)
	);

endmodule

FILE: rtl/core/tthc_datapath.sv
module tthc_datapath #(
	parameter int MAX_LEVEL = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tthc_pkg::cmd_t                cmd,
	output tthc_pkg::sts_t                sts,
	input  logic [tthc_pkg::FACE_W-1:0]   face,
	input  logic [tthc_pkg::LEVEL_W-1:0]  level,
	input  logic [tthc_pkg::COORD_W-1:0]  x_coord,
	input  logic [tthc_pkg::COORD_W-1:0]  y_coord,
	output logic [tthc_pkg::ID_W-1:0]     cell_id,
	output logic                          rejected
);
	import tthc_pkg::*;

	localparam int IDX_W  = 2 * MAX_LEVEL;
	localparam int CNT_W  = $clog2(MAX_LEVEL + 1);
	localparam int BIT_W  = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
	localparam int BASE_W = $clog2(IDX_W + 1);
	localparam int LOW_W  = FACE_SHIFT;

	logic [FACE_W-1:0]    face_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 reject_q;
	logic [MAX_LEVEL-1:0] u_q;
	logic [MAX_LEVEL-1:0] v_q;
	logic [IDX_W-1:0]     index_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ID_W-1:0]      cell_id_q;
	logic                 rejected_q;

	logic                 bad;
	logic [BIT_W-1:0]     bit_idx;
	logic                 rx;
	logic                 ry;
	logic [BASE_W-1:0]    base;
	logic [LOW_W-1:0]     low;

	assign bad = (face > FACE_W'(MAX_FACE)) || (level > LEVEL_W'(MAX_LEVEL));

	assign bit_idx = BIT_W'(cnt_q - 1'b1);
	assign rx      = u_q[bit_idx];
	assign ry      = v_q[bit_idx];

	// Left-align the index with its marker below it, under the face bits.
	assign base = BASE_W'(IDX_W) - BASE_W'({level_q, 1'b0});
	assign low  = LOW_W'({index_q, 1'b1}) << base;

	assign sts.done = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= bad ? '0 : CNT_W'(level);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			face_q   <= face;
			level_q  <= level;
			reject_q <= bad;
			index_q  <= '0;
			u_q      <= face[0] ? y_coord[MAX_LEVEL-1:0] : x_coord[MAX_LEVEL-1:0];
			v_q      <= face[0] ? x_coord[MAX_LEVEL-1:0] : y_coord[MAX_LEVEL-1:0];
		end else if (cmd.step) begin
			index_q <= IDX_W'({index_q, rx, rx ^ ry});
			if (!ry) begin
				if (rx) begin
					u_q <= ~v_q;
					v_q <= ~u_q;
				end else begin
					u_q <= v_q;
					v_q <= u_q;
				end
			end
		end
		if (cmd.finish) begin
			cell_id_q  <= reject_q ? '0 : {face_q, low};
			rejected_q <= reject_q;
		end
	end

	assign cell_id  = cell_id_q;
	assign rejected = rejected_q;

	// A digit is only taken while levels remain.
	a_step_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q != '0)
		else $error("step issued with no levels left");

endmodule

FILE: rtl/core/tthc_ctrl.sv
module tthc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output tthc_pkg::cmd_t cmd,
	input  tthc_pkg::sts_t sts
);
	import tthc_pkg::*;

	typedef enum logic {
		IDLE,
		BUSY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != IDLE);
	assign cmd.load   = (state_q == IDLE) && in_valid;
	assign cmd.step   = (state_q == BUSY) && !sts.done;
	assign cmd.finish = (state_q == BUSY) && sts.done && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= BUSY;
					end
				end
				BUSY: begin
					if (sts.done && out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_finish_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish))
		else $error("step and finish issued together");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished beat not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

endmodule
